FILE: hdl/bbs_pkg.sv
// Shared constants, types and helper functions of the binary binomial
// smoothing block. No dependencies; every other file but bbs_ram imports it.
`default_nettype none

package bbs_pkg;

  // Longest supported image row, in pixels.
  localparam int MAX_WIDTH = 1024;

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int THR_W      = 5;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  // The input row runs up to two past the last row while the frame drains.
  localparam int ROW_W  = CFG_H_W + 1;
  localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W = (WMAX_W > CFG_W_W) ? WMAX_W : CFG_W_W;
  localparam int SUM_W  = 5;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET     = CFG_W_W'(1024);
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET    = CFG_H_W'(1024);
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(8);

  localparam logic [PIX_W-1:0] PIXEL_ON  = PIX_W'(255);
  localparam logic [PIX_W-1:0] PIXEL_OFF = '0;

  // The func field: a pixel item; the other code is a flush item.
  localparam logic FUNC_PIXEL = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_SUM_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Window weights, oldest column first, upper row first within a column.
  localparam logic [2:0] WEIGHT [9] = '{3'd1, 3'd2, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1, 3'd2, 3'd1};

  // One feed step handed from the scan stage to the window stage.
  typedef struct packed {
    logic [COL_W-1:0] addr;
    logic             pix_bit;
    logic             r_ge1;
    logic             r_ge2;
    logic             c_zero;
    logic             c_one;
    logic             w_one;
    logic             last;
  } feed_t;

  function automatic logic [SUM_W-1:0] weighted_sum(logic [8:0] win);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      if (win[i]) begin
        acc = acc + SUM_W'(WEIGHT[i]);
      end
    end
    return acc;
  endfunction

  // Index of the last column of a row, with the width clamped to 1..MAX_WIDTH.
  function automatic logic [COL_W-1:0] last_col_f(logic [CFG_W_W-1:0] fw);
    logic [WCMP_W-1:0] fx;
    fx = WCMP_W'(fw);
    if (fw == '0) begin
      return '0;
    end else if (fx > WCMP_W'(MAX_WIDTH)) begin
      return COL_W'(MAX_WIDTH - 1);
    end else begin
      return COL_W'(fx - WCMP_W'(1));
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bbs_in_if.sv
// Input channel of the smoothing block: one grey pixel or flush item.
// Depends on bbs_pkg.
`default_nettype none

interface bbs_in_if import bbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output func, output pixel_value, input ready);
  modport sink   (input valid, input func, input pixel_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/bbs_out_if.sv
// Output channel of the smoothing block: one filtered pixel item.
// Depends on bbs_pkg.
`default_nettype none

interface bbs_out_if import bbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/bbs_cfg_if.sv
// Register write channel of the smoothing block.
// Depends on bbs_pkg.
`default_nettype none

interface bbs_cfg_if import bbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/binary_binomial_smoothing_3x3_core.sv
// Binary 3x3 binomial smoothing with threshold.
//
// pix_in takes grey pixels in raster order (func = pixel) or flush items.
// Each pixel becomes one bit (nonzero = object); the 3x3 window of bits is
// weighted 1 2 1 / 2 4 2 / 1 2 1 with zeros outside the image, and pix_out
// gives 255 when the sum reaches sum_threshold, else 0. Results trail the
// input by one row plus one pixel; after the last pixel, each flush item
// releases one pending result, and frame_end marks the last one of a frame.
// cfg writes registers (0 width, 1 height, 2 threshold); a width or height
// write restarts the frame; the user must write only while idle, unchecked.
// One item per clock while pix_out does not stall; a result passes the s1
// and output registers after its releasing item is accepted. The rate is
// set by the line store: a two-bit entry is read and written per item, with
// write-to-read forwarding. A one-row frame's first flush takes an extra step.
// Reset (rst, synchronous) restores the register defaults and starts a new
// frame; the line store needs no clearing. When pix_out stalls, one result
// waits in the output register while the next item is still taken; further
// input is held off until the register drains.
// Depends on bbs_pkg, the channel interfaces, bbs_scan, bbs_window, bbs_ram.
`default_nettype none

module binary_binomial_smoothing_3x3_core import bbs_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  bbs_in_if.sink   pix_in,
  bbs_out_if.source pix_out,
  bbs_cfg_if.sink  cfg
);

  logic [CFG_W_W-1:0] frame_width;
  logic [CFG_H_W-1:0] frame_height;
  logic [THR_W-1:0]   sum_threshold;
  logic               cfg_write;
  logic               restart;
  logic [COL_W-1:0]   last_col;

  logic               s1_free;
  logic               go;
  feed_t              feed;
  logic [1:0]         rd_data;
  logic               we;
  logic [COL_W-1:0]   waddr;
  logic [1:0]         wdata;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;
  assign restart   = cfg_write &&
                     ((cfg.index == REG_FRAME_WIDTH) || (cfg.index == REG_FRAME_HEIGHT));
  assign last_col  = last_col_f(frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= WIDTH_RESET;
      frame_height  <= HEIGHT_RESET;
      sum_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_FRAME_WIDTH:   frame_width   <= cfg.data[CFG_W_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg.data[CFG_H_W-1:0];
        REG_SUM_THRESHOLD: sum_threshold <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  bbs_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .restart  (restart),
    .last_col (last_col),
    .height   (frame_height),
    .s1_free  (s1_free),
    .go       (go),
    .feed     (feed)
  );

  bbs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (go),
    .raddr (feed.addr),
    .rdata (rd_data)
  );

  bbs_window u_window (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .threshold (sum_threshold),
    .go        (go),
    .feed      (feed),
    .rd_data   (rd_data),
    .s1_free   (s1_free),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .pix_out   (pix_out)
  );

endmodule

`default_nettype wire

FILE: hdl/bbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module bbs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bbs_scan.sv
// Scan stage: input row and column counters, feed issue and line store read.
// Depends on bbs_pkg and bbs_in_if.
`default_nettype none

module bbs_scan import bbs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  bbs_in_if.sink                  pix_in,
  input  wire logic               restart,
  input  wire logic [COL_W-1:0]   last_col,
  input  wire logic [CFG_H_W-1:0] height,
  input  wire logic               s1_free,
  output logic                    go,
  output feed_t                   feed
);

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [CFG_H_W-1:0] h_eff;
  logic               flush_phase;
  logic               extra;

  assign h_eff       = (height == '0) ? CFG_H_W'(1) : height;
  assign flush_phase = row >= ROW_W'(h_eff);
  // In a single-row frame the first drain step yields nothing, so that flush
  // item needs a second step: the first is issued without taking the item.
  assign extra = flush_phase && (row == ROW_W'(1)) && (col == '0);

  assign pix_in.ready = s1_free && !extra;
  assign go = pix_in.valid && s1_free && (flush_phase || (pix_in.func == FUNC_PIXEL));

  always_comb begin
    feed.addr    = col;
    feed.pix_bit = !flush_phase && (pix_in.pixel_value != '0);
    feed.r_ge1   = row != '0;
    feed.r_ge2   = row[ROW_W-1:1] != '0;
    feed.c_zero  = col == '0;
    feed.c_one   = col == COL_W'(1);
    feed.w_one   = last_col == '0;
    // The last pixel of a frame is always released by the first column of
    // the second row past the frame.
    feed.last    = (row == ROW_W'(h_eff) + ROW_W'(1)) && (col == '0);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (go) begin
      if (feed.last) begin
        col <= '0;
        row <= '0;
      end else if (col == last_col) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bbs_window.sv
// Window stage: forwards line store data, shifts the 3x3 bit window, writes the
// line store back, thresholds the weighted sum and holds the output register.
// Depends on bbs_pkg and bbs_out_if.
`default_nettype none

module bbs_window import bbs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic [THR_W-1:0] threshold,
  input  wire logic             go,
  input  wire feed_t            feed,
  input  wire logic [1:0]       rd_data,
  output logic                  s1_free,
  output logic                  we,
  output logic [COL_W-1:0]      waddr,
  output logic [1:0]            wdata,
  bbs_out_if.source             pix_out
);

  feed_t            s1;
  logic             s1_valid;
  logic             fwd_hit;
  logic [1:0]       fwd_data;
  logic [8:0]       window;

  logic             out_free;
  logic             commit;
  logic [1:0]       row_bits;
  logic             top;
  logic             mid;
  logic [8:0]       win_new;
  logic [8:0]       win_a;
  logic [8:0]       win_b;
  logic [8:0]       win_sel;
  logic             emit_a;
  logic             emit_b;
  logic [SUM_W-1:0] sum;

  assign out_free = !pix_out.valid || pix_out.ready;
  assign commit   = s1_valid && out_free;
  assign s1_free  = !s1_valid || out_free;

  // Bit 0 of an entry holds the previous row, bit 1 the row before it.
  assign row_bits = fwd_hit ? fwd_data : rd_data;
  assign top      = s1.r_ge2 && row_bits[1];
  assign mid      = s1.r_ge1 && row_bits[0];

  always_comb begin
    win_new = {s1.pix_bit, mid, top, window[8:3]};
    // Right border: the column past the row end is empty.
    win_a   = {3'b000, window[8:3]};
    if (s1.w_one) begin
      win_a[2:0] = 3'b000;
    end
    // Left border: the column before the row start is empty.
    win_b = win_new;
    if (s1.c_one) begin
      win_b[2:0] = 3'b000;
    end
    emit_a  = s1.c_zero && s1.r_ge2;
    emit_b  = !s1.c_zero && s1.r_ge1;
    win_sel = emit_a ? win_a : win_b;
    sum     = weighted_sum(win_sel);
  end

  assign we    = commit;
  assign waddr = s1.addr;
  assign wdata = {mid, s1.pix_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (go) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  // A read issued in the cycle of a write to the same entry sees old data.
  always_ff @(posedge clk) begin
    if (go) begin
      s1       <= feed;
      fwd_hit  <= commit && (s1.addr == feed.addr);
      fwd_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window <= '0;
    end else if (commit) begin
      window <= s1.last ? 9'b0 : win_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (commit && (emit_a || emit_b)) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && (emit_a || emit_b)) begin
      pix_out.pixel_out <= (sum >= SUM_W'(threshold)) ? PIXEL_ON : PIXEL_OFF;
      pix_out.frame_end <= s1.last;
    end
  end

endmodule

`default_nettype wire
